// ===== rtl/bta_pkg.sv =====
package bta_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 1024;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

	// field and register widths
	localparam int ADDR_W    = 32;
	localparam int SIZE_W    = 16;
	localparam int BS_W      = 8;
	localparam int BIU_W     = 11;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 32;
	localparam int DIV_W     = 32;
	localparam int DIV_CNT_W = $clog2(DIV_W + 1);
	localparam int PROD_W    = IDX_W + BS_W;

	// register reset values
	localparam logic [BS_W-1:0]   RESET_BLOCK_SIZE    = 8'd32;
	localparam logic [ADDR_W-1:0] RESET_BASE_ADDRESS  = 32'h6800_0000;
	localparam logic [BIU_W-1:0]  RESET_BLOCKS_IN_USE = 11'd1024;
	localparam logic [ADDR_W-1:0] ALL_ONES            = 32'hFFFF_FFFF;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_IN_USE = 2'd2;

	// request codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_BAD     = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_CLEAR,
		S_IDLE,
		S_PRECHK,
		S_DIV,
		S_CHECK,
		S_SCAN,
		S_FREE_RD,
		S_FREE_LEN,
		S_FILL,
		S_RESP
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    latch_in;
		logic    div_start;
		logic    scan_start;
		logic    scan_run;
		logic    clear_start;
		logic    mark_start;
		logic    unmark_start;
		logic    set_res;
		logic    res_use_addr;
		status_t res_code;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pre_bad;
		logic is_free;
		logic div_busy;
		logic alloc_no_fit;
		logic free_out_range;
		logic scan_hit;
		logic scan_miss;
		logic fill_busy;
	} dp_status_t;

endpackage

// ===== rtl/block_table_allocator_core.sv =====
// Block table allocator. A request is taken when start is high and busy is
// low; its single result appears on alloc_address and status for exactly one
// cycle with done high, and must be captured then. One request is handled at
// a time. The cost is set by the shared bit-serial divider (32 steps) and
// by the single port of the block table: an allocate's busy time grows with
// the entries scanned and the blocks marked, a free's with the blocks
// cleared. busy goes low between requests. After reset the table is cleared
// one entry per cycle, with busy high until it is done; configuration writes
// are taken during that time. cfg_ready is always high; write registers only
// while busy is low and no result is pending.
module block_table_allocator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           cmd,
	input  logic [bta_pkg::SIZE_W-1:0]     size_bytes,
	input  logic [bta_pkg::ADDR_W-1:0]     free_address,
	output logic                           done,
	output logic [bta_pkg::ADDR_W-1:0]     alloc_address,
	output logic [bta_pkg::STATUS_W-1:0]   status,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bta_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bta_pkg::CFG_W-1:0]      cfg_data
);

	bta_pkg::dp_cmd_t    ctl;
	bta_pkg::dp_status_t sts;

	// register writes are always accepted
	assign cfg_ready = 1'b1;

	bta_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	bta_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.size_bytes    (size_bytes),
		.free_address  (free_address),
		.ctl           (ctl),
		.sts           (sts),
		.alloc_address (alloc_address),
		.status        (status)
	);

endmodule

// ===== rtl/bta_ram.sv =====
module bta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/bta_div.sv =====
module bta_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bta_pkg::DIV_W-1:0]    dividend,
	input  logic [bta_pkg::BS_W-1:0]     divisor,
	output logic                         busy,
	output logic [bta_pkg::DIV_W-1:0]    quotient
);

	logic [bta_pkg::DIV_W-1:0]     quo_q;
	logic [bta_pkg::BS_W-1:0]      rem_q;
	logic [bta_pkg::BS_W-1:0]      dvs_q;
	logic [bta_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic [bta_pkg::BS_W:0]        shifted;
	logic                          fits;

	// one restoring step: bring down the next dividend bit
	assign shifted = {rem_q, quo_q[bta_pkg::DIV_W-1]};
	assign fits    = shifted >= {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= bta_pkg::DIV_CNT_W'(bta_pkg::DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == bta_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// quotient and remainder
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[bta_pkg::DIV_W-2:0], fits};
			rem_q <= fits ? bta_pkg::BS_W'(shifted - {1'b0, dvs_q})
			              : shifted[bta_pkg::BS_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/bta_datapath.sv =====
module bta_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bta_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bta_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             cmd,
	input  logic [bta_pkg::SIZE_W-1:0]       size_bytes,
	input  logic [bta_pkg::ADDR_W-1:0]       free_address,
	input  bta_pkg::dp_cmd_t                 ctl,
	output bta_pkg::dp_status_t              sts,
	output logic [bta_pkg::ADDR_W-1:0]       alloc_address,
	output logic [bta_pkg::STATUS_W-1:0]     status
);

	// configuration
	logic [bta_pkg::BS_W-1:0]   bs_q;
	logic [bta_pkg::ADDR_W-1:0] base_q;
	logic [bta_pkg::BIU_W-1:0]  biu_q;

	// latched request
	logic                        cmd_q;
	logic [bta_pkg::SIZE_W-1:0]  size_q;
	logic [bta_pkg::ADDR_W-1:0]  faddr_q;

	// divider
	logic [bta_pkg::DIV_W-1:0]   dividend;
	logic [bta_pkg::DIV_W-1:0]   quo;
	logic                        div_busy;

	// managed count
	logic [31:0]                 n32;
	logic [bta_pkg::CNT_W-1:0]   n_cnt;
	logic [bta_pkg::IDX_W-1:0]   quo_idx;
	logic [bta_pkg::CNT_W-1:0]   quo_need;

	// scan
	logic [bta_pkg::IDX_W-1:0]   rd_ptr_q;
	logic                        issue_q;
	logic                        vld_s1;
	logic [bta_pkg::IDX_W-1:0]   idx_s1;
	logic [bta_pkg::CNT_W-1:0]   run_q;
	logic [bta_pkg::CNT_W-1:0]   run_nx;
	logic                        hit;
	logic [bta_pkg::PROD_W-1:0]  prod_q;

	// fill engine
	logic [bta_pkg::IDX_W-1:0]   fill_ptr_q;
	logic [bta_pkg::CNT_W-1:0]   fill_left_q;
	logic [bta_pkg::CNT_W-1:0]   fill_val_q;
	logic                        fill_busy;
	logic [bta_pkg::CNT_W-1:0]   avail;
	logic [bta_pkg::CNT_W-1:0]   clr_len;

	// table port
	logic                        ram_we;
	logic [bta_pkg::IDX_W-1:0]   ram_addr;
	logic [bta_pkg::CNT_W-1:0]   ram_rdata;

	// result
	logic [bta_pkg::ADDR_W-1:0]  res_addr_q;
	bta_pkg::status_t            res_status_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q   <= bta_pkg::RESET_BLOCK_SIZE;
			base_q <= bta_pkg::RESET_BASE_ADDRESS;
			biu_q  <= bta_pkg::RESET_BLOCKS_IN_USE;
		end else if (cfg_we) begin
			case (cfg_index)
				bta_pkg::CFG_BLOCK_SIZE:    bs_q   <= cfg_data[bta_pkg::BS_W-1:0];
				bta_pkg::CFG_BASE_ADDRESS:  base_q <= cfg_data[bta_pkg::ADDR_W-1:0];
				bta_pkg::CFG_BLOCKS_IN_USE: biu_q  <= cfg_data[bta_pkg::BIU_W-1:0];
				default: ;
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (ctl.latch_in) begin
			cmd_q   <= cmd;
			size_q  <= size_bytes;
			faddr_q <= free_address;
		end
	end

	// managed count, capped at the table depth
	assign n32 = (32'(biu_q) > 32'(bta_pkg::TABLE_ENTRIES)) ? 32'(bta_pkg::TABLE_ENTRIES)
	                                                        : 32'(biu_q);
	assign n_cnt = n32[bta_pkg::CNT_W-1:0];

	// early rejects
	assign sts.is_free = (cmd_q == bta_pkg::CMD_FREE);
	assign sts.pre_bad = (bs_q == '0) ||
	                     (sts.is_free ? (faddr_q < base_q) : (size_q == '0));

	// round-up block count for allocate, block index for free
	assign dividend = sts.is_free ? (faddr_q - base_q)
	                              : (32'(size_q) + 32'(bs_q) - 32'd1);

	bta_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (dividend),
		.divisor  (bs_q),
		.busy     (div_busy),
		.quotient (quo)
	);

	assign sts.div_busy       = div_busy;
	assign sts.alloc_no_fit   = quo > n32;
	assign sts.free_out_range = quo >= n32;
	assign quo_idx            = quo[bta_pkg::IDX_W-1:0];
	assign quo_need           = quo[bta_pkg::CNT_W-1:0];

	// scan: reads issued top down, evaluated in the cycle after
	assign run_nx = (ram_rdata == '0) ? run_q + 1'b1 : '0;
	assign hit    = ctl.scan_run && vld_s1 && (run_nx == quo_need);
	assign sts.scan_hit  = hit;
	assign sts.scan_miss = ctl.scan_run && vld_s1 && !hit && (idx_s1 == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
		end else if (ctl.scan_start) begin
			issue_q <= 1'b1;
			vld_s1  <= 1'b0;
		end else if (ctl.scan_run) begin
			vld_s1 <= issue_q;
			if (issue_q && (rd_ptr_q == '0)) begin
				issue_q <= 1'b0;
			end
		end else begin
			issue_q <= 1'b0;
			vld_s1  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan_start) begin
			rd_ptr_q <= bta_pkg::IDX_W'(n32 - 32'd1);
			run_q    <= '0;
		end else if (ctl.scan_run) begin
			if (issue_q) begin
				idx_s1   <= rd_ptr_q;
				rd_ptr_q <= rd_ptr_q - 1'b1;
			end
			if (vld_s1) begin
				run_q <= run_nx;
			end
		end
	end

	// start address of the found run
	always_ff @(posedge clk) begin
		if (ctl.mark_start) begin
			prod_q <= bta_pkg::PROD_W'(idx_s1) * bta_pkg::PROD_W'(bs_q);
		end
	end

	// free: clear no further than the last managed entry
	assign avail   = n_cnt - bta_pkg::CNT_W'(quo_idx);
	assign clr_len = (ram_rdata < avail) ? ram_rdata : avail;

	// fill engine: reset clear, mark, unmark
	assign fill_busy     = (fill_left_q != '0);
	assign sts.fill_busy = fill_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_left_q <= '0;
		end else if (ctl.clear_start) begin
			fill_left_q <= bta_pkg::CNT_W'(bta_pkg::TABLE_ENTRIES);
		end else if (ctl.mark_start) begin
			fill_left_q <= quo_need;
		end else if (ctl.unmark_start) begin
			fill_left_q <= clr_len;
		end else if (fill_busy) begin
			fill_left_q <= fill_left_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear_start) begin
			fill_ptr_q <= '0;
			fill_val_q <= '0;
		end else if (ctl.mark_start) begin
			fill_ptr_q <= idx_s1;
			fill_val_q <= quo_need;
		end else if (ctl.unmark_start) begin
			fill_ptr_q <= quo_idx;
			fill_val_q <= '0;
		end else if (fill_busy) begin
			fill_ptr_q <= fill_ptr_q + 1'b1;
		end
	end

	// table port select
	always_comb begin
		ram_we = fill_busy;
		if (fill_busy) begin
			ram_addr = fill_ptr_q;
		end else if (ctl.scan_run) begin
			ram_addr = rd_ptr_q;
		end else begin
			ram_addr = quo_idx;
		end
	end

	bta_ram #(
		.WIDTH (bta_pkg::CNT_W),
		.DEPTH (bta_pkg::TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (fill_val_q),
		.rdata (ram_rdata)
	);

	// result registers
	always_ff @(posedge clk) begin
		if (ctl.set_res) begin
			res_status_q <= ctl.res_code;
			res_addr_q   <= ctl.res_use_addr ? (base_q + bta_pkg::ADDR_W'(prod_q))
			                                 : bta_pkg::ALL_ONES;
		end
	end

	assign alloc_address = res_addr_q;
	assign status        = res_status_q;

endmodule

// ===== rtl/bta_ctrl.sv =====
module bta_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bta_pkg::dp_status_t sts,
	output bta_pkg::dp_cmd_t    ctl,
	output logic                busy,
	output logic                done
);

	bta_pkg::state_t state_q;
	bta_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bta_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bta_pkg::S_INIT:  state_d = bta_pkg::S_CLEAR;
			bta_pkg::S_CLEAR: begin
				if (!sts.fill_busy) state_d = bta_pkg::S_IDLE;
			end
			bta_pkg::S_IDLE: begin
				if (start) state_d = bta_pkg::S_PRECHK;
			end
			bta_pkg::S_PRECHK: begin
				state_d = sts.pre_bad ? bta_pkg::S_RESP : bta_pkg::S_DIV;
			end
			bta_pkg::S_DIV: begin
				if (!sts.div_busy) state_d = bta_pkg::S_CHECK;
			end
			bta_pkg::S_CHECK: begin
				if (sts.is_free) begin
					state_d = sts.free_out_range ? bta_pkg::S_RESP : bta_pkg::S_FREE_RD;
				end else begin
					state_d = sts.alloc_no_fit ? bta_pkg::S_RESP : bta_pkg::S_SCAN;
				end
			end
			bta_pkg::S_SCAN: begin
				if (sts.scan_hit) begin
					state_d = bta_pkg::S_FILL;
				end else if (sts.scan_miss) begin
					state_d = bta_pkg::S_RESP;
				end
			end
			bta_pkg::S_FREE_RD:  state_d = bta_pkg::S_FREE_LEN;
			bta_pkg::S_FREE_LEN: state_d = bta_pkg::S_FILL;
			bta_pkg::S_FILL: begin
				if (!sts.fill_busy) state_d = bta_pkg::S_RESP;
			end
			bta_pkg::S_RESP: state_d = bta_pkg::S_IDLE;
			default:         state_d = bta_pkg::S_INIT;
		endcase
	end

	// outputs
	always_comb begin
		ctl          = '0;
		ctl.res_code = bta_pkg::ST_OK;
		case (state_q)
			bta_pkg::S_INIT: ctl.clear_start = 1'b1;
			bta_pkg::S_IDLE: ctl.latch_in = start;
			bta_pkg::S_PRECHK: begin
				if (sts.pre_bad) begin
					ctl.set_res  = 1'b1;
					ctl.res_code = bta_pkg::ST_BAD;
				end else begin
					ctl.div_start = 1'b1;
				end
			end
			bta_pkg::S_CHECK: begin
				if (sts.is_free) begin
					if (sts.free_out_range) begin
						ctl.set_res  = 1'b1;
						ctl.res_code = bta_pkg::ST_BAD;
					end
				end else if (sts.alloc_no_fit) begin
					ctl.set_res  = 1'b1;
					ctl.res_code = bta_pkg::ST_NOSPACE;
				end else begin
					ctl.scan_start = 1'b1;
				end
			end
			bta_pkg::S_SCAN: begin
				ctl.scan_run = 1'b1;
				if (sts.scan_hit) begin
					ctl.mark_start = 1'b1;
				end else if (sts.scan_miss) begin
					ctl.set_res  = 1'b1;
					ctl.res_code = bta_pkg::ST_NOSPACE;
				end
			end
			bta_pkg::S_FREE_LEN: ctl.unmark_start = 1'b1;
			bta_pkg::S_FILL: begin
				if (!sts.fill_busy) begin
					ctl.set_res      = 1'b1;
					ctl.res_code     = bta_pkg::ST_OK;
					ctl.res_use_addr = !sts.is_free;
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != bta_pkg::S_IDLE);
	assign done = (state_q == bta_pkg::S_RESP);

endmodule

// ===== rtl/bta_checker.sv =====
module bta_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           start,
	input logic                           busy,
	input logic                           cmd,
	input logic [bta_pkg::SIZE_W-1:0]     size_bytes,
	input logic [bta_pkg::ADDR_W-1:0]     free_address,
	input logic                           done,
	input logic [bta_pkg::ADDR_W-1:0]     alloc_address,
	input logic [bta_pkg::STATUS_W-1:0]   status,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic [bta_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [bta_pkg::CFG_W-1:0]      cfg_data
);

	// an accepted request keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after an accepted request");

	// no result in the cycle right after acceptance
	a_accept_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result strobe right after acceptance");

	// a result belongs to a request in flight
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// one result beat per request
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// failures carry the all-ones address
	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != bta_pkg::ST_OK) |-> alloc_address == bta_pkg::ALL_ONES)
		else $error("failed request returned an address");

endmodule

bind block_table_allocator_core bta_checker u_chk (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import bta_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 10_000_000;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		status_t           st;
	} alloc_reply_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	logic                 cmd = CMD_ALLOC;
	logic [SIZE_W-1:0]    size_bytes = '0;
	logic [ADDR_W-1:0]    free_address = '0;
	logic                 done;
	logic [ADDR_W-1:0]    alloc_address;
	logic [STATUS_W-1:0]  status;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_BLOCK_SIZE;
	logic [CFG_W-1:0]     cfg_data = '0;

	// shadow of the registers and the block table
	logic [BS_W-1:0]   cur_bs = RESET_BLOCK_SIZE;
	logic [ADDR_W-1:0] cur_base = RESET_BASE_ADDRESS;
	logic [BIU_W-1:0]  cur_biu = RESET_BLOCKS_IN_USE;
	logic [CNT_W-1:0]  blk_cnt [TABLE_ENTRIES];

	alloc_reply_t      replies_due [$];
	logic [ADDR_W-1:0] live_runs [$];
	logic [ADDR_W-1:0] last_freed = '0;
	bit                steady = 1'b0;
	int unsigned       mismatches = 0;
	int unsigned       cycles = 0;

	block_table_allocator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.size_bytes    (size_bytes),
		.free_address  (free_address),
		.done          (done),
		.alloc_address (alloc_address),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int unsigned managed_blocks();
		return (cur_biu > TABLE_ENTRIES) ? TABLE_ENTRIES : int'(cur_biu);
	endfunction

	// expected reply of one request, applied to the shadow table
	function automatic alloc_reply_t predict_reply(input logic c, input logic [SIZE_W-1:0] sz,
			input logic [ADDR_W-1:0] fa);
		alloc_reply_t r;
		int unsigned n, need, run, idx, cnt;
		n = managed_blocks();
		r.addr = ALL_ONES;
		r.st = ST_OK;
		if (c == CMD_ALLOC) begin
			if (sz == '0 || cur_bs == '0) begin
				r.st = ST_BAD;
			end else begin
				need = (32'(sz) + 32'(cur_bs) - 32'd1) / 32'(cur_bs);
				run = 0;
				r.st = ST_NOSPACE;
				// top-down scan for the first free run that fits
				for (int i = int'(n) - 1; i >= 0; i--) begin
					run = (blk_cnt[i] == '0) ? run + 1 : 0;
					if (run == need) begin
						for (int unsigned k = 0; k < need; k++)
							blk_cnt[i + k] = CNT_W'(need);
						r.addr = cur_base + 32'(i) * 32'(cur_bs);
						r.st = ST_OK;
						break;
					end
				end
			end
		end else begin
			if (cur_bs == '0 || fa < cur_base) begin
				r.st = ST_BAD;
			end else begin
				idx = (fa - cur_base) / 32'(cur_bs);
				if (idx >= n) begin
					r.st = ST_BAD;
				end else begin
					// clear the stored count, stopping at the last managed entry
					cnt = blk_cnt[idx];
					for (int unsigned k = 0; k < cnt && idx + k < n; k++)
						blk_cnt[idx + k] = '0;
				end
			end
		end
		return r;
	endfunction

	// one request beat; start drops at random while waiting
	task automatic send_request(input logic c, input logic [SIZE_W-1:0] sz,
			input logic [ADDR_W-1:0] fa);
		bit taken;
		alloc_reply_t r;
		taken = 1'b0;
		cmd <= c;
		size_bytes <= sz;
		free_address <= fa;
		start <= steady || ($urandom_range(99) >= 22);
		while (!taken) begin
			@(posedge clk);
			if (start && !busy)
				taken = 1'b1;
			else
				start <= steady || ($urandom_range(99) >= 22);
		end
		r = predict_reply(c, sz, fa);
		replies_due.push_back(r);
		if (c == CMD_ALLOC && r.st == ST_OK)
			live_runs.push_back(r.addr);
		if (c == CMD_FREE)
			last_freed = fa;
	endtask

	// wait until every reply is in and the block is idle
	task automatic drain();
		start <= 1'b0;
		do @(negedge clk); while (replies_due.size() != 0 || busy);
		@(posedge clk);
	endtask

	// write all registers, plus one beat to the unused index
	task automatic set_config(input logic [BS_W-1:0] bs, input logic [ADDR_W-1:0] base,
			input logic [BIU_W-1:0] biu);
		logic [CFG_IDX_W-1:0] regs [4];
		logic [CFG_W-1:0]     vals [4];
		bit                   taken;
		regs = '{CFG_UNUSED, CFG_BLOCK_SIZE, CFG_BASE_ADDRESS, CFG_BLOCKS_IN_USE};
		vals = '{$urandom(), {24'($urandom()), bs}, base, {21'($urandom()), biu}};
		foreach (regs[k]) begin
			taken = 1'b0;
			cfg_index <= regs[k];
			cfg_data <= vals[k];
			cfg_valid <= steady || ($urandom_range(99) >= 22);
			while (!taken) begin
				@(posedge clk);
				if (cfg_valid && cfg_ready)
					taken = 1'b1;
				else
					cfg_valid <= steady || ($urandom_range(99) >= 22);
			end
			case (regs[k])
				CFG_BLOCK_SIZE:    cur_bs = vals[k][BS_W-1:0];
				CFG_BASE_ADDRESS:  cur_base = vals[k];
				CFG_BLOCKS_IN_USE: cur_biu = vals[k][BIU_W-1:0];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
		live_runs.delete();
	endtask

	// reply checker
	always @(posedge clk) begin : check_reply
		alloc_reply_t want;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$error("unexpected reply: alloc_address %h status %0d", alloc_address, status);
				mismatches++;
			end else begin
				want = replies_due.pop_front();
				if (alloc_address !== want.addr) begin
					$error("alloc_address: expected %h, got %h", want.addr, alloc_address);
					mismatches++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					mismatches++;
				end
			end
		end
	end

	// reset register values: size extremes, unaligned, double and stray frees
	task automatic test_reset_geometry();
		send_request(CMD_ALLOC, 16'd1, 32'hFFFF_FFFF);
		send_request(CMD_ALLOC, 16'd0, 32'h0);
		send_request(CMD_ALLOC, 16'hFFFF, 32'h0);
		send_request(CMD_ALLOC, 16'd33, 32'h0);
		send_request(CMD_FREE, 16'hFFFF, RESET_BASE_ADDRESS + 32'd1021 * 32 + 32'd5);
		send_request(CMD_FREE, 16'h0, RESET_BASE_ADDRESS + 32'd1021 * 32);
		send_request(CMD_FREE, 16'h0, RESET_BASE_ADDRESS - 32'd1);
		send_request(CMD_FREE, 16'h0, RESET_BASE_ADDRESS + 32'd1024 * 32);
		send_request(CMD_FREE, 16'h0, 32'hFFFF_FFFF);
		send_request(CMD_FREE, 16'h0, RESET_BASE_ADDRESS + 32'd1023 * 32);
		// whole table in one run, then nothing left
		send_request(CMD_ALLOC, 16'd32768, 32'h0);
		send_request(CMD_ALLOC, 16'd1, 32'h0);
		send_request(CMD_FREE, 16'h0, RESET_BASE_ADDRESS);
	endtask

	// zero block size rejects both requests
	task automatic test_zero_block_size();
		drain();
		set_config(8'd0, RESET_BASE_ADDRESS, 11'd16);
		send_request(CMD_ALLOC, 16'd64, 32'h0);
		send_request(CMD_FREE, 16'h0, RESET_BASE_ADDRESS);
	endtask

	// zero and oversized block counts, address wrap
	task automatic test_count_limits();
		drain();
		set_config(8'd255, 32'hFFFF_FF00, 11'd0);
		send_request(CMD_ALLOC, 16'd1, 32'h0);
		send_request(CMD_FREE, 16'h0, 32'hFFFF_FF00);
		drain();
		set_config(8'd255, 32'hFFFF_FF00, 11'h7FF);
		send_request(CMD_ALLOC, 16'd255, 32'h0);
		send_request(CMD_ALLOC, 16'd256, 32'h0);
		// wrapped address sits below the base
		send_request(CMD_FREE, 16'h0, 32'hFFFF_FF00 + 32'd1023 * 32'd255);
	endtask

	// a run cut by a smaller block count clears only up to the end
	task automatic test_clear_at_end();
		drain();
		set_config(8'd1, 32'h0, 11'd8);
		send_request(CMD_ALLOC, 16'd3, 32'h0);
		drain();
		set_config(8'd1, 32'h0, 11'd6);
		send_request(CMD_FREE, 16'h0, 32'd5);
		drain();
		set_config(8'd1, 32'h0, 11'd1024);
		send_request(CMD_FREE, 16'h0, 32'd6);
		send_request(CMD_FREE, 16'h0, 32'd1021);
		send_request(CMD_FREE, 16'h0, 32'd1023);
	endtask

	// mostly allocate/free pairs, some malformed requests, then release all
	task automatic run_traffic(input int unsigned items);
		int unsigned n, lim, roll, pick;
		logic [ADDR_W-1:0] a;
		n = managed_blocks();
		lim = 32'(cur_bs) * (n / 4 + 1);
		if (lim > 65535)
			lim = 65535;
		for (int unsigned j = 0; j < items; j++) begin
			roll = $urandom_range(99);
			if (roll >= 45 && roll < 80 && live_runs.size() > 0) begin
				// release a live run, sometimes at an unaligned address
				pick = $urandom_range(live_runs.size() - 1);
				a = live_runs[pick];
				if (cur_bs > 1 && $urandom_range(1))
					a = a + $urandom_range(cur_bs - 1);
				live_runs.delete(pick);
				send_request(CMD_FREE, 16'($urandom()), a);
			end else if (roll < 80) begin
				send_request(CMD_ALLOC, 16'($urandom_range(1, lim)), $urandom());
			end else begin
				case ($urandom_range(5))
					0: send_request(CMD_ALLOC, 16'($urandom()), $urandom());
					1: send_request(CMD_FREE, 16'($urandom()), $urandom());
					2: send_request(CMD_FREE, 16'($urandom()),
							cur_base - 32'($urandom_range(1, 4)));
					3: send_request(CMD_FREE, 16'($urandom()),
							cur_base + n * 32'(cur_bs) + $urandom_range(255));
					4: send_request(CMD_ALLOC, 16'd0, $urandom());
					default: send_request(CMD_FREE, 16'($urandom()), last_freed);
				endcase
			end
		end
		while (live_runs.size() > 0)
			send_request(CMD_FREE, 16'($urandom()), live_runs.pop_front());
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 7; p++) begin
			drain();
			steady = (p == 1);
			case (p)
				0: set_config(8'd1, $urandom(), 11'd16);
				1: set_config(8'd255, $urandom(), 11'd40);
				2: set_config(8'($urandom_range(2, 254)), 32'h0, 11'($urandom_range(1, 64)));
				3: set_config(8'($urandom_range(2, 254)),
						32'hFFFF_F000 | 32'($urandom_range(255)), 11'd64);
				4: set_config(8'($urandom_range(2, 254)), $urandom(), 11'd1024);
				5: set_config(RESET_BLOCK_SIZE, RESET_BASE_ADDRESS, 11'd1);
				default: set_config(8'($urandom_range(1, 255)), $urandom(),
						11'($urandom_range(2, 200)));
			endcase
			run_traffic(36);
		end
		steady = 1'b0;
	endtask

	initial begin
		foreach (blk_cnt[i])
			blk_cnt[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_geometry();
		test_zero_block_size();
		test_count_limits();
		test_clear_at_end();
		test_random_traffic();
		drain();
		// catch any stray reply
		repeat (64) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
